// ----- design/sqlist_pkg.sv -----
package sqlist_pkg;

  // Number of cells built into the row.
  localparam int CAPACITY = 512;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 10;
  localparam int POS_W  = 10;
  localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  // Reset value of the capacity register.
  localparam logic [CNT_W-1:0] MAX_LENGTH_RESET = CNT_W'(512);

  // Depth of the radix-8 read tree that gathers one cell's word.
  function automatic int tree_levels(int n);
    int lvl;
    int span;
    lvl  = 0;
    span = 1;
    while (span < n) begin
      span = span * 8;
      lvl  = lvl + 1;
    end
    return (lvl < 1) ? 1 : lvl;
  endfunction

  localparam int TREE_LVLS   = tree_levels(CAPACITY);
  localparam int TREE_LEAVES = 8 ** TREE_LVLS;
  localparam int TREE_NODES  = (TREE_LEAVES - 1) / 7;

  typedef enum logic [1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } command_t;

  localparam logic [1:0] ST_OK           = 2'd0;
  localparam logic [1:0] ST_BAD_POSITION = 2'd1;
  localparam logic [1:0] ST_FULL         = 2'd2;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic              ins;
    logic              del;
    logic              rd;
    logic [IDX_W-1:0]  tgt;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- design/sqlist_cell.sv -----
module sqlist_cell (
  input  logic                       clk,
  input  sqlist_pkg::cell_ctrl_t     ctrl,
  input  logic [sqlist_pkg::IDX_W-1:0]  idx,
  input  logic [sqlist_pkg::DATA_W-1:0] left_data,
  input  logic [sqlist_pkg::DATA_W-1:0] right_data,
  output logic [sqlist_pkg::DATA_W-1:0] data,
  output logic [sqlist_pkg::DATA_W-1:0] leaf
);
  import sqlist_pkg::*;

  logic [DATA_W-1:0] data_next;

  // Insert pulls from the lower neighbor above the target, delete pulls
  // from the upper neighbor at and above the target.
  always_comb begin
    data_next = data;
    if (ctrl.ins && (idx > ctrl.tgt)) begin
      data_next = left_data;
    end else if (ctrl.ins && (idx == ctrl.tgt)) begin
      data_next = ctrl.value;
    end else if (ctrl.del && (idx >= ctrl.tgt)) begin
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
    leaf <= (ctrl.rd && (idx == ctrl.tgt)) ? data : '0;
  end

endmodule

// ----- design/sqlist_gather.sv -----
module sqlist_gather (
  input  logic                          clk,
  input  logic [sqlist_pkg::DATA_W-1:0] leaf [sqlist_pkg::CAPACITY],
  output logic [sqlist_pkg::DATA_W-1:0] root
);
  import sqlist_pkg::*;

  logic [DATA_W-1:0] leaf_w [TREE_LEAVES];
  logic [DATA_W-1:0] node   [TREE_NODES];
  logic [DATA_W-1:0] kid    [TREE_NODES][8];

  // Only one leaf is nonzero during a find, so an OR tree selects it.
  for (genvar k = 0; k < TREE_LEAVES; k++) begin : g_leaf
    if (k < CAPACITY) begin : g_used
      assign leaf_w[k] = leaf[k];
    end else begin : g_pad
      assign leaf_w[k] = '0;
    end
  end

  for (genvar n = 0; n < TREE_NODES; n++) begin : g_node
    for (genvar m = 0; m < 8; m++) begin : g_kid
      if (8 * n + 1 + m < TREE_NODES) begin : g_inner
        assign kid[n][m] = node[8 * n + 1 + m];
      end else begin : g_outer
        assign kid[n][m] = leaf_w[8 * n + 1 + m - TREE_NODES];
      end
    end

    always_ff @(posedge clk) begin
      node[n] <= kid[n][0] | kid[n][1] | kid[n][2] | kid[n][3] |
                 kid[n][4] | kid[n][5] | kid[n][6] | kid[n][7];
    end
  end

  assign root = node[0];

endmodule

// ----- design/sequential_list_insert_delete.sv -----
// Channel    Handshake           Payload
// ---------  ------------------  -----------------------------------------
// command    start / busy        command, position, value_in
// result     done (one cycle)    status, value_out, count
// config     cfg_write           cfg_data (list capacity in use)
//
// An item is accepted at an edge with start high and busy low. Its result
// is shown for one cycle with done high, once the found word has passed the
// cell leaf registers and every level of the OR tree. The next item can be
// accepted at the edge that ends that cycle; no new item is taken while one
// is in flight. TREE_LVLS is the depth of the registered radix-8 OR tree that
// gathers a found word from the cell row; inserts and deletes finish in the
// row on the accept edge itself. Synchronous reset empties the list and sets
// the capacity register to 512; cell contents are not cleared. The receiver
// cannot stall: done is a strobe and the result must be taken when it appears.
module sequential_list_insert_delete (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         command,
  input  logic signed [sqlist_pkg::POS_W-1:0]  position,
  input  logic signed [sqlist_pkg::DATA_W-1:0] value_in,
  input  logic                               cfg_write,
  input  logic [sqlist_pkg::CNT_W-1:0]       cfg_data,
  output logic                               done,
  output logic [1:0]                         status,
  output logic signed [sqlist_pkg::DATA_W-1:0] value_out,
  output logic [sqlist_pkg::CNT_W-1:0]       count
);
  import sqlist_pkg::*;

  logic [CNT_W-1:0]     max_length;
  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     count_next;
  logic [1:0]           status_q;
  logic [1:0]           status_next;
  logic [TREE_LVLS:0]   vld;
  logic                 accept;
  cell_ctrl_t           ctrl;

  logic signed [POS_W:0] pos_ext;
  logic signed [POS_W:0] cnt_ext;
  logic signed [POS_W:0] pos_p1;
  logic                  pos_lt_n;
  logic                  pos_ge_m1;
  logic                  list_full;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_leaf [CAPACITY];
  logic [DATA_W-1:0] root;

  // Busy covers the tree flight of the item in progress. The cycle that
  // shows the result is free: status and count hold until the next accept
  // edge and value_out until the edge that ends the done cycle, where the receiver samples them.
  assign busy   = |vld[TREE_LVLS-1:0];
  assign accept = start && !busy;

  // Range checks are done one bit wider so that -1 and the count compare
  // as signed numbers.
  assign pos_ext   = {position[POS_W-1], position};
  assign cnt_ext   = $signed({1'b0, count_q});
  assign pos_p1    = pos_ext + (POS_W+1)'(1);
  assign pos_lt_n  = pos_ext < cnt_ext;
  assign pos_ge_m1 = pos_ext >= -(POS_W+1)'(1);
  // The usable capacity is the smaller of the register and the row length.
  assign list_full = (count_q >= max_length) || (int'(count_q) >= CAPACITY);

  always_comb begin
    ctrl        = '0;
    ctrl.value  = value_in;
    ctrl.tgt    = IDX_W'(position[POS_W-1:0]);
    status_next = ST_BAD_POSITION;
    count_next  = count_q;
    case (command)
      CMD_FIND: begin
        if (!position[POS_W-1] && pos_lt_n) begin
          status_next = ST_OK;
          ctrl.rd     = accept;
        end
      end
      CMD_INSERT: begin
        // The new word lands just above the given position.
        ctrl.tgt = IDX_W'(pos_p1);
        if (!pos_ge_m1 || !pos_lt_n) begin
          status_next = ST_BAD_POSITION;
        end else if (list_full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_OK;
          ctrl.ins    = accept;
          count_next  = count_q + 1'b1;
        end
      end
      CMD_DELETE: begin
        if (!position[POS_W-1] && pos_lt_n) begin
          status_next = ST_OK;
          ctrl.del    = accept;
          count_next  = count_q - 1'b1;
        end
      end
      default: begin
        status_next = ST_BAD_POSITION;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
      count_q    <= '0;
      vld        <= '0;
    end else begin
      if (cfg_write) begin
        max_length <= cfg_data;
      end
      if (accept) begin
        count_q <= count_next;
      end
      vld <= {vld[TREE_LVLS-1:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_q <= status_next;
    end
  end

  // The row of cells: each one takes its word from a neighbor on a shift.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = value_in;
    end else begin : g_left
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_right
      assign right_w = cell_data[i+1];
    end

    sqlist_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (IDX_W'(i)),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[i]),
      .leaf       (cell_leaf[i])
    );
  end

  sqlist_gather u_gather (
    .clk  (clk),
    .leaf (cell_leaf),
    .root (root)
  );

  // Only a successful find drives a nonzero leaf, so the root is already
  // zero for every other command.
  assign done      = vld[TREE_LVLS];
  assign status    = status_q;
  assign value_out = root;
  assign count     = count_q;

endmodule
